@@ design/reversible_deque_defines.svh @@
// assertion macros shared by the checker
`ifndef REVERSIBLE_DEQUE_DEFINES_SVH
`define REVERSIBLE_DEQUE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define RDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reversible_deque check failed");

// next-cycle implication, reset masks the check
`define RDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reversible_deque check failed");

`endif

@@ design/rdq_pkg.sv @@
`default_nettype none
package rdq_pkg;
  localparam int DEPTH     = 1024;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = ADDR_BITS + 1;
  localparam int WORD_BITS = 32;

  typedef logic [2:0] op_t;
  localparam op_t OP_PUSH_BACK  = 3'd0;
  localparam op_t OP_PUSH_FRONT = 3'd1;
  localparam op_t OP_POP_FRONT  = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_TOGGLE     = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_POPPED = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;
endpackage
`default_nettype wire

@@ design/rdq_if.sv @@
`default_nettype none
interface rdq_in_if import rdq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface rdq_out_if import rdq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] popped;
  logic [10:0] occupancy;

  modport source (output valid, output status, output popped, output occupancy, input ready);
  modport sink   (input valid, input status, input popped, input occupancy, output ready);
endinterface
`default_nettype wire

@@ design/reversible_deque.sv @@
// channel   dir  beat fields
// in_ch     in   op[2:0], value[31:0]
// out_ch    out  status[1:0], popped[31:0], occupancy[10:0]
//
// a result passes through the pending stage into the output register after its beat is taken
// one beat per cycle while the output side takes every result; the ring memory's
// registered read sets the pending stage between acceptance and output
// reset clears state, head, count, reverse flag and the output valid; the ring itself is not cleared
// a stall on the output holds the pending result and closes the input
`default_nettype none
module reversible_deque import rdq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rdq_in_if.sink     in_ch,
  rdq_out_if.source  out_ch
);
  logic [WORD_BITS-1:0] ring_mem [DEPTH];
  logic [WORD_BITS-1:0] mem_q_r;

  logic [ADDR_BITS-1:0] head_r, head_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic                 rev_r, rev_nxt;
  state_t               state_r, state_nxt;

  status_t              pend_status_r, pend_status_nxt;
  logic [CNT_BITS-1:0]  pend_occ_r;
  logic                 pend_pop_r, pend_pop_nxt;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [31:0]          out_popped_r;
  logic [CNT_BITS-1:0]  out_occ_r;

  logic                 out_free, in_ready, accept, out_load;
  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] wr_addr, rd_addr;
  logic                 tail_ins, head_ins, head_rem, tail_rem;
  logic                 full, empty;
  op_t                  op;

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ready;
  assign op       = in_ch.op;
  assign full     = count_r == CNT_BITS'(DEPTH);
  assign empty    = count_r == '0;

  // physical ends after the reverse flag
  assign tail_ins = (op == OP_PUSH_BACK && !rev_r) || (op == OP_PUSH_FRONT && rev_r);
  assign head_ins = (op == OP_PUSH_FRONT && !rev_r) || (op == OP_PUSH_BACK && rev_r);
  assign head_rem = (op == OP_POP_FRONT && !rev_r) || (op == OP_POP_BACK && rev_r);
  assign tail_rem = (op == OP_POP_BACK && !rev_r) || (op == OP_POP_FRONT && rev_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_free && !accept) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_WAIT: begin
        in_ready = out_free;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    head_nxt        = head_r;
    count_nxt       = count_r;
    rev_nxt         = rev_r;
    pend_status_nxt = ST_DONE;
    pend_pop_nxt    = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    wr_addr         = head_r + count_r[ADDR_BITS-1:0];
    rd_addr         = head_r;
    if (head_ins) wr_addr = head_r - ADDR_BITS'(1);
    if (tail_rem) rd_addr = head_r + ADDR_BITS'(count_r - CNT_BITS'(1));
    if (accept) begin
      if (tail_ins || head_ins) begin
        if (full) begin
          pend_status_nxt = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_BITS'(1);
          if (head_ins) head_nxt = head_r - ADDR_BITS'(1);
        end
      end else if (head_rem || tail_rem) begin
        if (empty) begin
          pend_status_nxt = ST_EMPTY;
        end else begin
          mem_re          = 1'b1;
          pend_status_nxt = ST_POPPED;
          pend_pop_nxt    = 1'b1;
          count_nxt       = count_r - CNT_BITS'(1);
          if (head_rem) head_nxt = head_r + ADDR_BITS'(1);
        end
      end else if (op == OP_TOGGLE) begin
        rev_nxt = !rev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[wr_addr] <= in_ch.value[WORD_BITS-1:0];
    if (mem_re) mem_q_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status_r <= pend_status_nxt;
      pend_pop_r    <= pend_pop_nxt;
      pend_occ_r    <= count_nxt;
    end
    if (out_load) begin
      out_status_r <= pend_status_r;
      out_popped_r <= pend_pop_r ? mem_q_r : '0;
      out_occ_r    <= pend_occ_r;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.popped    = out_popped_r;
  assign out_ch.occupancy = out_occ_r;
endmodule
`default_nettype wire

@@ design/rdq_checker.sv @@
`default_nettype none
`include "reversible_deque_defines.svh"
module rdq_checker import rdq_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] popped,
  input wire logic [10:0] occupancy
);
  `RDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
  `RDQ_ASSERT_NOW(a_empty_zero, out_valid && status == ST_EMPTY, occupancy == '0 && popped == '0)
  `RDQ_ASSERT_NOW(a_full_depth, out_valid && status == ST_FULL, occupancy == 11'(DEPTH))
  `RDQ_ASSERT_NOW(a_pop_only, out_valid && popped != '0, status == ST_POPPED)
  `RDQ_ASSERT_NOW(a_occ_bound, out_valid, occupancy <= 11'(DEPTH))
endmodule

bind reversible_deque rdq_checker u_rdq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .popped    (out_ch.popped),
  .occupancy (out_ch.occupancy)
);
`default_nettype wire

@@ tb/tb_reversible_deque.sv @@
`timescale 1ns / 1ps
module tb_reversible_deque;
  import rdq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int QUIET_FIRST  = 150;
  localparam int QUIET_LAST   = 330;
  localparam int RANDOM_BEATS = 380;

  typedef struct {
    op_t                op;
    logic signed [31:0] value;
    bit                 hold;
  } deque_op_t;

  typedef struct {
    status_t             status;
    logic signed [31:0]  popped;
    logic [CNT_BITS-1:0] occupancy;
  } deque_outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  rdq_in_if  in_ch ();
  rdq_out_if out_ch ();

  reversible_deque dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  deque_op_t      ops_to_send[$];
  deque_outcome_t outcomes_due[$];
  deque_op_t      nxt;
  deque_outcome_t got;
  deque_outcome_t want;

  logic signed [31:0]   ring_words [DEPTH];
  logic [ADDR_BITS-1:0] dq_head;
  logic [CNT_BITS-1:0]  dq_count;
  bit                   dq_rev;

  int cycles    = 0;
  int beats_in  = 0;
  int beats_out = 0;
  int errors    = 0;
  int n_popped  = 0;
  int n_empty   = 0;
  int n_dropped = 0;
  int peak_occ  = 0;

  function automatic bit roll_idle();
    if (cycles >= QUIET_FIRST && cycles < QUIET_LAST) return 1'b0;
    return $urandom_range(99) < 13;
  endfunction

  function automatic status_t push_word(bit at_front, logic signed [31:0] w);
    if (int'(dq_count) >= DEPTH) return ST_FULL;
    if (at_front) begin
      dq_head = ADDR_BITS'((int'(dq_head) + DEPTH - 1) % DEPTH);
      ring_words[dq_head] = w;
    end else begin
      ring_words[(int'(dq_head) + int'(dq_count)) % DEPTH] = w;
    end
    dq_count = dq_count + 1'b1;
    return ST_DONE;
  endfunction

  function automatic status_t pop_word(bit at_front, output logic signed [31:0] w);
    w = '0;
    if (dq_count == 0) return ST_EMPTY;
    if (at_front) begin
      w = ring_words[dq_head];
      dq_head = ADDR_BITS'((int'(dq_head) + 1) % DEPTH);
    end else begin
      w = ring_words[(int'(dq_head) + int'(dq_count) - 1) % DEPTH];
    end
    dq_count = dq_count - 1'b1;
    return ST_POPPED;
  endfunction

  function automatic deque_outcome_t apply_deque_op(op_t op, logic signed [31:0] value);
    deque_outcome_t res;
    logic signed [31:0] w;
    res.status = ST_DONE;
    res.popped = '0;
    w = '0;
    case (op)
      OP_PUSH_BACK:  res.status = push_word(dq_rev, value);
      OP_PUSH_FRONT: res.status = push_word(!dq_rev, value);
      OP_POP_FRONT:  res.status = pop_word(!dq_rev, w);
      OP_POP_BACK:   res.status = pop_word(dq_rev, w);
      OP_TOGGLE:     dq_rev = !dq_rev;
      default: ;
    endcase
    if (res.status == ST_POPPED) res.popped = w;
    res.occupancy = dq_count;
    return res;
  endfunction

  task automatic queue_op(op_t op, logic signed [31:0] value, bit hold = 1'b0);
    deque_op_t item;
    item.op    = op;
    item.value = value;
    item.hold  = hold;
    ops_to_send.insert(ops_to_send.size(), item);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(15))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh00000000;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t pick_push();
    return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  function automatic op_t pick_pop();
    return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) beats_in <= beats_in + 1;
      if (!in_ch.valid || in_ch.ready) begin
        if (ops_to_send.size() != 0 && !roll_idle() &&
            (!ops_to_send[0].hold || (!in_ch.valid && beats_out == beats_in))) begin
          nxt = ops_to_send[0];
          ops_to_send.delete(0);
          in_ch.valid <= 1'b1;
          in_ch.op    <= nxt.op;
          in_ch.value <= nxt.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !roll_idle();
      if (out_ch.valid && out_ch.ready) begin
        beats_out <= beats_out + 1;
        got.status    = out_ch.status;
        got.popped    = out_ch.popped;
        got.occupancy = out_ch.occupancy;
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none got status %0d popped %0d occ %0d",
                   $time, got.status, got.popped, got.occupancy);
          errors++;
        end else begin
          want = outcomes_due[0];
          outcomes_due.delete(0);
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.popped !== want.popped) begin
            $display("%0t: popped expected %0d got %0d", $time, want.popped, got.popped);
            errors++;
          end
          if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
                     got.occupancy);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = apply_deque_op(in_ch.op, in_ch.value);
        outcomes_due.insert(outcomes_due.size(), want);
        case (want.status)
          ST_POPPED: n_popped++;
          ST_EMPTY:  n_empty++;
          ST_FULL:   n_dropped++;
          default: ;
        endcase
        if (int'(want.occupancy) > peak_occ) peak_occ = want.occupancy;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int k;
    int r;
    int push_pct;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_PUSH_BACK;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    dq_head      = '0;
    dq_count     = '0;
    dq_rev       = 1'b0;

    // empty pops, unused codes, field extremes, reversed ends
    queue_op(OP_POP_FRONT, 32'sd0);
    queue_op(OP_POP_BACK, -32'sd1);
    queue_op(op_t'(5), -32'sd1);
    queue_op(op_t'(6), 32'sd0);
    queue_op(op_t'(7), 32'sh7fffffff);
    queue_op(OP_PUSH_BACK, 32'sh7fffffff);
    queue_op(OP_PUSH_FRONT, 32'sh80000000);
    queue_op(OP_PUSH_BACK, 32'sd0);
    queue_op(OP_PUSH_FRONT, -32'sd1);
    queue_op(OP_POP_FRONT, 32'sd0);
    queue_op(OP_POP_BACK, 32'sd0);
    queue_op(OP_TOGGLE, 32'sh12345678);
    queue_op(OP_PUSH_BACK, 32'sh55555555);
    queue_op(OP_PUSH_FRONT, 32'shaaaaaaaa);
    queue_op(OP_POP_FRONT, 32'sd0);
    queue_op(OP_POP_BACK, 32'sd0);
    queue_op(OP_POP_FRONT, 32'sd0);
    queue_op(OP_POP_BACK, 32'sd0);
    queue_op(OP_POP_BACK, 32'sd0);
    queue_op(OP_TOGGLE, 32'sd0);
    queue_op(OP_TOGGLE, 32'sd0);
    queue_op(OP_TOGGLE, 32'sd0);

    // random mix, pushes ahead in the first half and pops ahead in the second
    for (k = 0; k < RANDOM_BEATS; k++) begin
      push_pct = (k < RANDOM_BEATS / 2) ? 70 : 25;
      r = $urandom_range(99);
      if (r < push_pct) begin
        queue_op(pick_push(), pick_word(), k == 0 || k == RANDOM_BEATS / 2);
      end else if (r < 90) begin
        queue_op(pick_pop(), pick_word(), k == 0 || k == RANDOM_BEATS / 2);
      end else if (r < 97) begin
        queue_op(OP_TOGGLE, pick_word(), k == 0 || k == RANDOM_BEATS / 2);
      end else begin
        queue_op(op_t'($urandom_range(7, 5)), pick_word(),
                 k == 0 || k == RANDOM_BEATS / 2);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_to_send.size() != 0 || in_ch.valid || beats_out < beats_in) @(posedge clk);
    repeat (10) @(posedge clk);
    if (outcomes_due.size() != 0) begin
      $display("%0t: %0d results still outstanding, expected 0", $time, outcomes_due.size());
      errors++;
    end

    $display("run: %0d beats checked, %0d words popped, %0d empty pops, %0d full drops",
             beats_out, n_popped, n_empty, n_dropped);
    $display("run: peak occupancy %0d with both ends used in either direction", peak_occ);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
